FILE: rtl/hdmc_pkg.sv
// ----------------------------------------------------------------------------
// hdmc_pkg
// Shared widths, codes and controller/datapath interface types for the
// hard-disk Monte Carlo step block.
// ----------------------------------------------------------------------------
`default_nettype none

package hdmc_pkg;

  localparam int MAX_DISKS_DEF = 256;

  localparam int CoordW    = 17;
  localparam int StepW     = 16;
  localparam int DiamW     = 36;
  localparam int WhichW    = 8;
  localparam int StatusW   = 3;
  localparam int SlotW     = 8;
  localparam int CountOutW = 9;
  localparam int CfgIdxW   = 1;
  localparam int SqW       = 2 * CoordW;

  localparam logic [CoordW-1:0] BOX_RESET  = CoordW'(128000);
  localparam logic [DiamW-1:0]  DIAM_RESET = DiamW'(104857600);

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED     = 3'd0,
    ST_INS_OVERLAP  = 3'd1,
    ST_FULL         = 3'd2,
    ST_MOVED        = 3'd3,
    ST_OUT_OF_BOX   = 3'd4,
    ST_MOVE_OVERLAP = 3'd5,
    ST_BAD_INDEX    = 3'd6
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOX  = 1'b0,
    REG_DIAM = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEL_ZERO  = 2'd0,
    SEL_DISK  = 2'd1,
    SEL_HIT   = 2'd2,
    SEL_WRITE = 2'd3
  } slot_sel_t;

  typedef struct packed {
    logic      item_load;
    logic      cand_move;
    logic      scan_start;
    logic      scan_stop;
    logic      wr_en;
    logic      res_set;
    status_t   res_code;
    slot_sel_t slot_sel;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic is_move;
    logic full;
    logic bad_index;
    logic out_of_box;
    logic scan_hit;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/hard_disk_monte_carlo_step_top.sv
// ----------------------------------------------------------------------------
// hard_disk_monte_carlo_step_top
// Hard-disk Monte Carlo step: insert and displacement trials on a store of
// disk centres in a square box.
//
// Usage:
// An item word (kind, pos_x, pos_y, which_disk, step_x, step_y) is taken at
// a clock edge with item_valid high and item_stall low. Each item returns
// exactly one result word (status, slot, disk_count) on the result channel,
// taken when result_valid is high and result_stall is low.
// Items are handled one at a time. A store-full or bad-index item presents
// its result word after the check and done states, an out-of-box move
// after the check, fetch and done states. An item that scans the store
// presents it on the first overlap, or else after the scan and the write
// state (a move fetches its disk first); the next item is taken once the
// controller is idle again. The overlap test reads one stored centre per
// cycle via the single store read port into square, sum and compare stages.
// The result sits in an output register; while the receiver stalls, the
// next item is still accepted and worked on, and its result waits until
// the register is freed. Reset empties the store (disk count zero), clears
// the result channel and restores box_size and diameter_squared.
// Configuration words are taken on cfg_valid; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module hard_disk_monte_carlo_step_top
  import hdmc_pkg::*;
#(
  parameter int MAX_DISKS = MAX_DISKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CfgIdxW-1:0]    cfg_index,
  input  wire logic [DiamW-1:0]      cfg_data,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire logic                  kind,
  input  wire logic [CoordW-1:0]     pos_x,
  input  wire logic [CoordW-1:0]     pos_y,
  input  wire logic [WhichW-1:0]     which_disk,
  input  wire logic [StepW-1:0]      step_x,
  input  wire logic [StepW-1:0]      step_y,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [StatusW-1:0]         status,
  output logic [SlotW-1:0]           slot,
  output logic [CountOutW-1:0]       disk_count
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  hdmc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .stat       (stat)
  );

  hdmc_datapath #(
    .MAX_DISKS (MAX_DISKS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .kind         (kind),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .which_disk   (which_disk),
    .step_x       (step_x),
    .step_y       (step_y),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .status       (status),
    .slot         (slot),
    .disk_count   (disk_count)
  );

endmodule

`default_nettype wire

FILE: rtl/hdmc_ctrl.sv
// ----------------------------------------------------------------------------
// hdmc_ctrl
// Sequencer for one item: decode, fetch of the moved disk, overlap scan,
// store write and hand-off of the result word to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hdmc_ctrl
  import hdmc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_stall,
  output cmd_t       cmd,
  input  wire stat_t stat
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_FETCH = 6'b000100,
    S_SCAN  = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cmd.item_load  = 1'b0;
    cmd.cand_move  = 1'b0;
    cmd.scan_start = 1'b0;
    cmd.scan_stop  = 1'b0;
    cmd.wr_en      = 1'b0;
    cmd.res_set    = 1'b0;
    cmd.res_code   = ST_INSERTED;
    cmd.slot_sel   = SEL_ZERO;
    cmd.out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.item_load = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.is_move) begin
          if (stat.full) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_FULL;
            cmd.slot_sel = SEL_ZERO;
            state_next   = S_DONE;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end else if (stat.bad_index) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_BAD_INDEX;
          cmd.slot_sel = SEL_DISK;
          state_next   = S_DONE;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.cand_move = 1'b1;
        if (stat.out_of_box) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OUT_OF_BOX;
          cmd.slot_sel = SEL_DISK;
          state_next   = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_hit) begin
          cmd.scan_stop = 1'b1;
          cmd.res_set   = 1'b1;
          cmd.res_code  = stat.is_move ? ST_MOVE_OVERLAP : ST_INS_OVERLAP;
          cmd.slot_sel  = SEL_HIT;
          state_next    = S_DONE;
        end else if (stat.scan_done) begin
          cmd.scan_stop = 1'b1;
          state_next    = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr_en    = 1'b1;
        cmd.res_set  = 1'b1;
        cmd.res_code = stat.is_move ? ST_MOVED : ST_INSERTED;
        cmd.slot_sel = SEL_WRITE;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/hdmc_datapath.sv
// ----------------------------------------------------------------------------
// hdmc_datapath
// Centre store, configuration registers, item registers, the pipelined
// overlap test (read, square, sum and compare) and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hdmc_datapath
  import hdmc_pkg::*;
#(
  parameter int MAX_DISKS = MAX_DISKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output stat_t                      stat,
  input  wire logic                  cfg_valid,
  input  wire logic [CfgIdxW-1:0]    cfg_index,
  input  wire logic [DiamW-1:0]      cfg_data,
  input  wire logic                  kind,
  input  wire logic [CoordW-1:0]     pos_x,
  input  wire logic [CoordW-1:0]     pos_y,
  input  wire logic [WhichW-1:0]     which_disk,
  input  wire logic [StepW-1:0]      step_x,
  input  wire logic [StepW-1:0]      step_y,
  input  wire logic                  result_stall,
  output logic                       result_valid,
  output logic [StatusW-1:0]         status,
  output logic [SlotW-1:0]           slot,
  output logic [CountOutW-1:0]       disk_count
);

  localparam int IdxW   = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
  localparam int CountW = $clog2(MAX_DISKS + 1);
  localparam int CmpW   = (CountW > WhichW) ? CountW : WhichW;
  localparam int PosW   = CoordW + 2;

  logic [CoordW-1:0] mem_x [MAX_DISKS];
  logic [CoordW-1:0] mem_y [MAX_DISKS];

  logic [CoordW-1:0] box_size;
  logic [DiamW-1:0]  diam_sq;
  logic [CountW-1:0] count;

  logic              item_move;
  logic [CmpW-1:0]   item_which;
  logic [StepW-1:0]  item_step_x;
  logic [StepW-1:0]  item_step_y;
  logic [CoordW-1:0] cand_x;
  logic [CoordW-1:0] cand_y;

  logic              scan_active;
  logic [CountW-1:0] issue_idx;
  logic              issuing;
  logic [IdxW-1:0]   rd_addr;
  logic [IdxW-1:0]   wr_addr;
  logic [IdxW-1:0]   disk_idx;

  logic [CoordW-1:0] rx;
  logic [CoordW-1:0] ry;
  logic              v1;
  logic [IdxW-1:0]   idx1;
  logic              v2;
  logic              skip2;
  logic [IdxW-1:0]   idx2;
  logic [SqW-1:0]    sqx;
  logic [SqW-1:0]    sqy;
  logic              v3;
  logic              hit3;
  logic [IdxW-1:0]   idx3;

  logic signed [CoordW:0]     dx;
  logic signed [CoordW:0]     dy;
  logic signed [2*CoordW+1:0] px;
  logic signed [2*CoordW+1:0] py;
  logic [SqW:0]               dist_sq;

  logic signed [PosW-1:0] nx;
  logic signed [PosW-1:0] ny;
  logic signed [PosW-1:0] box_s;
  logic                   oob;

  status_t           res_code;
  logic [IdxW-1:0]   res_slot;
  logic [IdxW-1:0]   res_slot_next;

  assign disk_idx = IdxW'(item_which);
  assign issuing  = scan_active && (issue_idx < count);
  assign rd_addr  = scan_active ? issue_idx[IdxW-1:0] : disk_idx;
  assign wr_addr  = item_move ? disk_idx : count[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      box_size <= BOX_RESET;
      diam_sq  <= DIAM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BOX:  box_size <= cfg_data[CoordW-1:0];
        REG_DIAM: diam_sq  <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_move   <= kind;
      item_which  <= CmpW'(which_disk);
      item_step_x <= step_x;
      item_step_y <= step_y;
      cand_x      <= pos_x;
      cand_y      <= pos_y;
    end else if (cmd.cand_move) begin
      cand_x <= nx[CoordW-1:0];
      cand_y <= ny[CoordW-1:0];
    end
  end

  assign box_s = $signed({2'b00, box_size});
  assign nx    = $signed({2'b00, rx}) + $signed({{(PosW-StepW){item_step_x[StepW-1]}}, item_step_x});
  assign ny    = $signed({2'b00, ry}) + $signed({{(PosW-StepW){item_step_y[StepW-1]}}, item_step_y});
  assign oob   = (nx < 0) || (ny < 0) || (nx > box_s) || (ny > box_s);

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_x[wr_addr] <= cand_x;
      mem_y[wr_addr] <= cand_y;
    end
    rx <= mem_x[rd_addr];
    ry <= mem_y[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.wr_en && !item_move) begin
      count <= count + CountW'(1);
    end
  end

  assign dx      = $signed({1'b0, rx}) - $signed({1'b0, cand_x});
  assign dy      = $signed({1'b0, ry}) - $signed({1'b0, cand_y});
  assign px      = dx * dx;
  assign py      = dy * dy;
  assign dist_sq = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_stop || cmd.scan_start) begin
      scan_active <= cmd.scan_start && !rst;
      issue_idx   <= '0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
    end else begin
      if (issuing) begin
        issue_idx <= issue_idx + CountW'(1);
      end
      v1 <= issuing;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    idx1  <= issue_idx[IdxW-1:0];
    idx2  <= idx1;
    skip2 <= item_move && (idx1 == disk_idx);
    sqx   <= px[SqW-1:0];
    sqy   <= py[SqW-1:0];
    idx3  <= idx2;
    hit3  <= !skip2 && (DiamW'(dist_sq) < diam_sq);
  end

  always_comb begin
    unique case (cmd.slot_sel)
      SEL_ZERO:  res_slot_next = '0;
      SEL_DISK:  res_slot_next = disk_idx;
      SEL_HIT:   res_slot_next = idx3;
      SEL_WRITE: res_slot_next = wr_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_code <= cmd.res_code;
      if (cmd.slot_sel == SEL_DISK) begin
        res_slot <= IdxW'(item_which);
      end else begin
        res_slot <= res_slot_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status     <= res_code;
      slot       <= (cmd.out_load && res_code == ST_BAD_INDEX) ?
                    SlotW'(item_which) : SlotW'(res_slot);
      disk_count <= CountOutW'(count);
    end
  end

  assign stat.is_move    = item_move;
  assign stat.full       = (count >= CountW'(MAX_DISKS));
  assign stat.bad_index  = (item_which >= CmpW'(count));
  assign stat.out_of_box = oob;
  assign stat.scan_hit   = v3 && hit3;
  assign stat.scan_done  = scan_active && !issuing && !v1 && !v2 && !v3;
  assign stat.out_free   = !result_valid || !result_stall;

endmodule

`default_nettype wire

FILE: rtl/hdmc_checker.sv
// ----------------------------------------------------------------------------
// hdmc_checker
// Port-level checks of the hard-disk Monte Carlo step block, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hdmc_checker
  import hdmc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  item_valid,
  input wire logic                  item_stall,
  input wire logic                  result_valid,
  input wire logic                  result_stall,
  input wire logic [StatusW-1:0]    status,
  input wire logic [SlotW-1:0]      slot,
  input wire logic [CountOutW-1:0]  disk_count
);

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word present after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("second item taken while one is in work");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(status)
      && $stable(slot) && $stable(disk_count)))
    else $error("stalled result word changed");

  a_insert_slot: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_INSERTED) |-> (slot == 8'(disk_count - 9'd1)))
    else $error("inserted slot does not match disk count");

  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_FULL) |-> (slot == '0))
    else $error("store full result with nonzero slot");

endmodule

bind hard_disk_monte_carlo_step_top hdmc_checker u_hdmc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .slot         (slot),
  .disk_count   (disk_count)
);

`default_nettype wire
